[rtl/tlom_pkg.sv]
// Shared constants and types of the two-layer occupancy map.
// Field widths, default sizes, command and status codes, sequencer states.
// No dependencies.
package tlom_pkg;

    localparam int CMD_W = 4;
    localparam int ID_W = 6;
    localparam int ST_W = 3;

    localparam int VERTICES_DEF = 64;
    localparam int OBJECTS_DEF = 63;
    localparam int AGENTS_DEF = 63;

    typedef enum logic [CMD_W-1:0] {
        CMD_PLACE_OBJ     = 4'd0,
        CMD_REMOVE_OBJ    = 4'd1,
        CMD_PLACE_AGENT   = 4'd2,
        CMD_REMOVE_AGENT  = 4'd3,
        CMD_CLEAN         = 4'd4,
        CMD_MOVE_AGENT    = 4'd5,
        CMD_AGENT_CARRY   = 4'd6,
        CMD_OBJ_CARRY     = 4'd7,
        CMD_QUERY_VERTEX  = 4'd8,
        CMD_OBJ_LOC       = 4'd9,
        CMD_AGENT_LOC     = 4'd10
    } cmd_e;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_BAD_ID   = 3'd1,
        ST_OCCUPIED = 3'd2,
        ST_UNPLACED = 3'd3,
        ST_NOTHING  = 3'd4
    } status_e;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_CARRY,
        S_WRITE,
        S_DONE
    } state_e;

endpackage

[rtl/tlom_if.sv]
// Valid/ready channel interfaces of the two-layer occupancy map.
// Depends on tlom_pkg for the field widths.
interface tlom_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [tlom_pkg::CMD_W-1:0]  command;
    logic [tlom_pkg::ID_W-1:0]   entity_num;
    logic [tlom_pkg::ID_W-1:0]   vertex_num;

    modport source (output valid, command, entity_num, vertex_num, input ready);
    modport sink (input valid, command, entity_num, vertex_num, output ready);
endinterface

interface tlom_res_if;
    logic                        valid;
    logic                        ready;
    logic [tlom_pkg::ST_W-1:0]   status;
    logic [tlom_pkg::ID_W-1:0]   object_here;
    logic [tlom_pkg::ID_W-1:0]   agent_here;
    logic [tlom_pkg::ID_W-1:0]   location;
    logic                        location_valid;

    modport source (output valid, status, object_here, agent_here, location, location_valid,
                    input ready);
    modport sink (input valid, status, object_here, agent_here, location, location_valid,
                  output ready);
endinterface

[rtl/tlom_layer.sv]
// One layer of the occupancy map: entity-to-vertex and vertex-to-entity memories.
// Each memory has one write port and one registered read port.
// Depends on tlom_pkg for default sizes.
module tlom_layer #(
    parameter int VERTICES = tlom_pkg::VERTICES_DEF,
    parameter int COUNT = tlom_pkg::OBJECTS_DEF
) (
    input  logic                           clk,
    input  logic [$clog2(COUNT+1)-1:0]     place_rd_addr,
    output logic [$clog2(VERTICES):0]      place_rd_data,
    input  logic                           place_we,
    input  logic [$clog2(COUNT+1)-1:0]     place_wr_addr,
    input  logic [$clog2(VERTICES):0]      place_wr_data,
    input  logic [$clog2(VERTICES)-1:0]    occ_rd_addr,
    output logic [$clog2(COUNT+1)-1:0]     occ_rd_data,
    input  logic                           occ_we,
    input  logic [$clog2(VERTICES)-1:0]    occ_wr_addr,
    input  logic [$clog2(COUNT+1)-1:0]     occ_wr_data
);

    localparam int VW = $clog2(VERTICES);
    localparam int EW = $clog2(COUNT + 1);
    localparam int PW = VW + 1;

    // Place entries hold a placed bit above the vertex number.
    logic [PW-1:0] place_mem [0:COUNT];
    logic [EW-1:0] occ_mem [0:VERTICES-1];
    logic [PW-1:0] place_rd_reg;
    logic [EW-1:0] occ_rd_reg;

    always_ff @(posedge clk)
    begin
        if (place_we)
        begin
            place_mem[place_wr_addr] <= place_wr_data;
        end
        place_rd_reg <= place_mem[place_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (occ_we)
        begin
            occ_mem[occ_wr_addr] <= occ_wr_data;
        end
        occ_rd_reg <= occ_mem[occ_rd_addr];
    end

    assign place_rd_data = place_rd_reg;
    assign occ_rd_data = occ_rd_reg;

endmodule

[rtl/two_layer_occupancy_map.sv]
// Two-layer occupancy map, top level: command sequencer around two layer memories.
// Depends on tlom_pkg, tlom_if and tlom_layer.
//
// Usage: commands arrive on the cmd channel (command, entity_num, vertex_num) and
// each gives exactly one item on the res channel (status, object_here,
// agent_here, location, location_valid). An item is taken when valid and ready
// are both high. The block works on one command at a time; cmd.ready is high
// only while it waits for a command.
// From the accepting edge the sequencer steps through EVAL and DONE for queries,
// removals, cleaning, placing an unplaced entity and commands refused at the
// first check; through EVAL, WRITE and DONE for re-placing or moving an entity
// (its old vertex is vacated in a second write); through EVAL, CARRY and DONE
// for refused combined moves that reached the carry check; and through EVAL,
// CARRY, WRITE and DONE for combined moves, which read the mover's location,
// then the other layer's occupant there, then write. res.valid rises as DONE
// hands the result on, and cmd.ready rises together with it.
// After reset a clearing pass writes every memory entry before the first
// command is accepted. A finished result sits in an output register; while the
// receiver stalls it holds, the next command is still worked on, and its result
// waits in the block with cmd.ready low until the held item is taken.
module two_layer_occupancy_map #(
    parameter int VERTICES = tlom_pkg::VERTICES_DEF,
    parameter int OBJECTS = tlom_pkg::OBJECTS_DEF,
    parameter int AGENTS = tlom_pkg::AGENTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    tlom_cmd_if.sink      cmd,
    tlom_res_if.source    res
);

    localparam int ID_W = tlom_pkg::ID_W;
    localparam int VW = $clog2(VERTICES);
    localparam int OEW = $clog2(OBJECTS + 1);
    localparam int AEW = $clog2(AGENTS + 1);
    localparam int PW = VW + 1;
    localparam int MAXE = (OBJECTS > AGENTS) ? OBJECTS + 1 : AGENTS + 1;
    localparam int MAXD = (VERTICES > MAXE) ? VERTICES : MAXE;
    localparam int CW = $clog2(MAXD);

    tlom_pkg::state_e  state_reg, state_next;
    logic [CW-1:0]     clr_cnt_reg;

    tlom_pkg::cmd_e    cmd_reg;
    logic [ID_W-1:0]   ent_reg;
    logic [ID_W-1:0]   vtx_reg;

    logic [VW-1:0]     here_reg, here_next;
    logic              busy_reg, busy_next;
    logic              wclr_o_reg, wclr_o_next;
    logic              wclr_a_reg, wclr_a_next;

    tlom_pkg::status_e st_reg, st_next;
    logic [ID_W-1:0]   oh_reg, oh_next;
    logic [ID_W-1:0]   ah_reg, ah_next;
    logic [ID_W-1:0]   loc_reg, loc_next;
    logic              locv_reg, locv_next;

    logic              out_valid_reg;
    tlom_pkg::status_e out_st_reg;
    logic [ID_W-1:0]   out_oh_reg;
    logic [ID_W-1:0]   out_ah_reg;
    logic [ID_W-1:0]   out_loc_reg;
    logic              out_locv_reg;

    logic [OEW-1:0]    op_rd_addr;
    logic [PW-1:0]     op_q;
    logic              op_we;
    logic [OEW-1:0]    op_wa;
    logic [PW-1:0]     op_wd;
    logic [VW-1:0]     oo_rd_addr;
    logic [OEW-1:0]    oo_q;
    logic              oo_we;
    logic [VW-1:0]     oo_wa;
    logic [OEW-1:0]    oo_wd;

    logic [AEW-1:0]    ap_rd_addr;
    logic [PW-1:0]     ap_q;
    logic              ap_we;
    logic [AEW-1:0]    ap_wa;
    logic [PW-1:0]     ap_wd;
    logic [VW-1:0]     ao_rd_addr;
    logic [AEW-1:0]    ao_q;
    logic              ao_we;
    logic [VW-1:0]     ao_wa;
    logic [AEW-1:0]    ao_wd;

    logic              op_placed, ap_placed;
    logic [VW-1:0]     op_where, ap_where;
    logic              v_ok, o_id_ok, a_id_ok;
    logic [OEW-1:0]    o_ent;
    logic [AEW-1:0]    a_ent;
    logic [VW-1:0]     v_idx;
    logic [PW-1:0]     v_place;
    logic              out_free;

    tlom_pkg::status_e ev_st;
    logic              ev_carry;
    logic              ev_clr;
    tlom_pkg::status_e cr_st;

    tlom_layer #(
        .VERTICES (VERTICES),
        .COUNT    (OBJECTS)
    ) u_obj_layer (
        .clk           (clk),
        .place_rd_addr (op_rd_addr),
        .place_rd_data (op_q),
        .place_we      (op_we),
        .place_wr_addr (op_wa),
        .place_wr_data (op_wd),
        .occ_rd_addr   (oo_rd_addr),
        .occ_rd_data   (oo_q),
        .occ_we        (oo_we),
        .occ_wr_addr   (oo_wa),
        .occ_wr_data   (oo_wd)
    );

    tlom_layer #(
        .VERTICES (VERTICES),
        .COUNT    (AGENTS)
    ) u_agent_layer (
        .clk           (clk),
        .place_rd_addr (ap_rd_addr),
        .place_rd_data (ap_q),
        .place_we      (ap_we),
        .place_wr_addr (ap_wa),
        .place_wr_data (ap_wd),
        .occ_rd_addr   (ao_rd_addr),
        .occ_rd_data   (ao_q),
        .occ_we        (ao_we),
        .occ_wr_addr   (ao_wa),
        .occ_wr_data   (ao_wd)
    );

    assign op_placed = op_q[VW];
    assign op_where  = op_q[VW-1:0];
    assign ap_placed = ap_q[VW];
    assign ap_where  = ap_q[VW-1:0];

    assign v_ok    = 32'(vtx_reg) < VERTICES;
    assign o_id_ok = (ent_reg != '0) && (32'(ent_reg) <= OBJECTS);
    assign a_id_ok = (ent_reg != '0) && (32'(ent_reg) <= AGENTS);
    assign o_ent   = OEW'(ent_reg);
    assign a_ent   = AEW'(ent_reg);
    assign v_idx   = VW'(vtx_reg);
    assign v_place = {1'b1, v_idx};

    assign out_free = !out_valid_reg || res.ready;

    // Read addresses: the command's fields at acceptance, then the mover's
    // vertex for the second read of a combined move.
    assign op_rd_addr = OEW'(cmd.entity_num);
    assign ap_rd_addr = AEW'(cmd.entity_num);
    assign oo_rd_addr = (state_reg == tlom_pkg::S_EVAL) ? ap_where : VW'(cmd.vertex_num);
    assign ao_rd_addr = (state_reg == tlom_pkg::S_EVAL) ? op_where : VW'(cmd.vertex_num);

    always_comb
    begin
        ev_st = tlom_pkg::ST_OK;
        ev_carry = 1'b0;
        ev_clr = 1'b0;
        case (cmd_reg)
            tlom_pkg::CMD_PLACE_OBJ:
            begin
                if (!o_id_ok || !v_ok)
                    ev_st = tlom_pkg::ST_BAD_ID;
                else if (oo_q != '0)
                    ev_st = tlom_pkg::ST_OCCUPIED;
                else
                    ev_clr = op_placed;
            end
            tlom_pkg::CMD_REMOVE_OBJ:
            begin
                if (!o_id_ok)
                    ev_st = tlom_pkg::ST_BAD_ID;
                else if (!op_placed)
                    ev_st = tlom_pkg::ST_UNPLACED;
            end
            tlom_pkg::CMD_PLACE_AGENT:
            begin
                if (!a_id_ok || !v_ok)
                    ev_st = tlom_pkg::ST_BAD_ID;
                else if (ao_q != '0)
                    ev_st = tlom_pkg::ST_OCCUPIED;
                else
                    ev_clr = ap_placed;
            end
            tlom_pkg::CMD_REMOVE_AGENT:
            begin
                if (!a_id_ok)
                    ev_st = tlom_pkg::ST_BAD_ID;
                else if (!ap_placed)
                    ev_st = tlom_pkg::ST_UNPLACED;
            end
            tlom_pkg::CMD_CLEAN:
            begin
                if (!v_ok)
                    ev_st = tlom_pkg::ST_BAD_ID;
            end
            tlom_pkg::CMD_MOVE_AGENT:
            begin
                if (!a_id_ok || !v_ok)
                    ev_st = tlom_pkg::ST_BAD_ID;
                else if (!ap_placed)
                    ev_st = tlom_pkg::ST_UNPLACED;
                else if (ao_q != '0)
                    ev_st = tlom_pkg::ST_OCCUPIED;
                else
                    ev_clr = 1'b1;
            end
            tlom_pkg::CMD_AGENT_CARRY:
            begin
                if (!a_id_ok || !v_ok)
                    ev_st = tlom_pkg::ST_BAD_ID;
                else if (!ap_placed)
                    ev_st = tlom_pkg::ST_UNPLACED;
                else
                    ev_carry = 1'b1;
            end
            tlom_pkg::CMD_OBJ_CARRY:
            begin
                if (!o_id_ok || !v_ok)
                    ev_st = tlom_pkg::ST_BAD_ID;
                else if (!op_placed)
                    ev_st = tlom_pkg::ST_UNPLACED;
                else
                    ev_carry = 1'b1;
            end
            tlom_pkg::CMD_QUERY_VERTEX:
            begin
                if (!v_ok)
                    ev_st = tlom_pkg::ST_BAD_ID;
            end
            tlom_pkg::CMD_OBJ_LOC:
            begin
                if (!o_id_ok)
                    ev_st = tlom_pkg::ST_BAD_ID;
            end
            tlom_pkg::CMD_AGENT_LOC:
            begin
                if (!a_id_ok)
                    ev_st = tlom_pkg::ST_BAD_ID;
            end
            default:
            begin
                ev_st = tlom_pkg::ST_BAD_ID;
            end
        endcase

        // In the carry step the other layer's occupant read data holds the entity at the mover's vertex.
        if ((cmd_reg == tlom_pkg::CMD_AGENT_CARRY) ? (oo_q == '0) : (ao_q == '0))
            cr_st = tlom_pkg::ST_NOTHING;
        else if (busy_reg)
            cr_st = tlom_pkg::ST_OCCUPIED;
        else
            cr_st = tlom_pkg::ST_OK;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tlom_pkg::S_CLEAR:
            begin
                if (clr_cnt_reg == CW'(MAXD - 1))
                    state_next = tlom_pkg::S_IDLE;
            end
            tlom_pkg::S_IDLE:
            begin
                if (cmd.valid)
                    state_next = tlom_pkg::S_EVAL;
            end
            tlom_pkg::S_EVAL:
            begin
                if (ev_carry)
                    state_next = tlom_pkg::S_CARRY;
                else if (ev_clr)
                    state_next = tlom_pkg::S_WRITE;
                else
                    state_next = tlom_pkg::S_DONE;
            end
            tlom_pkg::S_CARRY:
            begin
                if (cr_st == tlom_pkg::ST_OK)
                    state_next = tlom_pkg::S_WRITE;
                else
                    state_next = tlom_pkg::S_DONE;
            end
            tlom_pkg::S_WRITE:
            begin
                state_next = tlom_pkg::S_DONE;
            end
            tlom_pkg::S_DONE:
            begin
                if (out_free)
                    state_next = tlom_pkg::S_IDLE;
            end
            default:
            begin
                state_next = tlom_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        op_we = 1'b0;
        op_wa = '0;
        op_wd = '0;
        oo_we = 1'b0;
        oo_wa = '0;
        oo_wd = '0;
        ap_we = 1'b0;
        ap_wa = '0;
        ap_wd = '0;
        ao_we = 1'b0;
        ao_wa = '0;
        ao_wd = '0;
        here_next = here_reg;
        busy_next = busy_reg;
        wclr_o_next = wclr_o_reg;
        wclr_a_next = wclr_a_reg;
        st_next = st_reg;
        oh_next = oh_reg;
        ah_next = ah_reg;
        loc_next = loc_reg;
        locv_next = locv_reg;

        case (state_reg)
            tlom_pkg::S_CLEAR:
            begin
                op_we = 32'(clr_cnt_reg) <= OBJECTS;
                op_wa = OEW'(clr_cnt_reg);
                ap_we = 32'(clr_cnt_reg) <= AGENTS;
                ap_wa = AEW'(clr_cnt_reg);
                oo_we = 32'(clr_cnt_reg) < VERTICES;
                oo_wa = VW'(clr_cnt_reg);
                ao_we = 32'(clr_cnt_reg) < VERTICES;
                ao_wa = VW'(clr_cnt_reg);
            end
            tlom_pkg::S_EVAL:
            begin
                st_next = ev_st;
                oh_next = '0;
                ah_next = '0;
                loc_next = '0;
                locv_next = 1'b0;
                here_next = (cmd_reg == tlom_pkg::CMD_PLACE_OBJ ||
                             cmd_reg == tlom_pkg::CMD_OBJ_CARRY) ? op_where : ap_where;
                busy_next = (oo_q != '0) || (ao_q != '0);
                wclr_o_next = ev_carry ||
                              (ev_clr && cmd_reg == tlom_pkg::CMD_PLACE_OBJ);
                wclr_a_next = ev_carry ||
                              (ev_clr && cmd_reg != tlom_pkg::CMD_PLACE_OBJ);
                if (ev_st == tlom_pkg::ST_OK)
                begin
                    case (cmd_reg)
                        tlom_pkg::CMD_PLACE_OBJ:
                        begin
                            op_we = 1'b1;
                            op_wa = o_ent;
                            op_wd = v_place;
                            oo_we = 1'b1;
                            oo_wa = v_idx;
                            oo_wd = o_ent;
                        end
                        tlom_pkg::CMD_REMOVE_OBJ:
                        begin
                            op_we = 1'b1;
                            op_wa = o_ent;
                            oo_we = 1'b1;
                            oo_wa = op_where;
                        end
                        tlom_pkg::CMD_PLACE_AGENT, tlom_pkg::CMD_MOVE_AGENT:
                        begin
                            ap_we = 1'b1;
                            ap_wa = a_ent;
                            ap_wd = v_place;
                            ao_we = 1'b1;
                            ao_wa = v_idx;
                            ao_wd = a_ent;
                        end
                        tlom_pkg::CMD_REMOVE_AGENT:
                        begin
                            ap_we = 1'b1;
                            ap_wa = a_ent;
                            ao_we = 1'b1;
                            ao_wa = ap_where;
                        end
                        tlom_pkg::CMD_CLEAN:
                        begin
                            op_we = oo_q != '0;
                            op_wa = oo_q;
                            oo_we = oo_q != '0;
                            oo_wa = v_idx;
                            ap_we = ao_q != '0;
                            ap_wa = ao_q;
                            ao_we = ao_q != '0;
                            ao_wa = v_idx;
                        end
                        tlom_pkg::CMD_QUERY_VERTEX:
                        begin
                            oh_next = ID_W'(oo_q);
                            ah_next = ID_W'(ao_q);
                        end
                        tlom_pkg::CMD_OBJ_LOC:
                        begin
                            loc_next = op_placed ? ID_W'(op_where) : '0;
                            locv_next = op_placed;
                        end
                        tlom_pkg::CMD_AGENT_LOC:
                        begin
                            loc_next = ap_placed ? ID_W'(ap_where) : '0;
                            locv_next = ap_placed;
                        end
                        default:
                        begin
                            op_we = 1'b0;
                        end
                    endcase
                end
            end
            tlom_pkg::S_CARRY:
            begin
                st_next = cr_st;
                if (cr_st == tlom_pkg::ST_OK)
                begin
                    if (cmd_reg == tlom_pkg::CMD_AGENT_CARRY)
                    begin
                        op_we = 1'b1;
                        op_wa = oo_q;
                        op_wd = v_place;
                        oo_we = 1'b1;
                        oo_wa = v_idx;
                        oo_wd = oo_q;
                        ap_we = 1'b1;
                        ap_wa = a_ent;
                        ap_wd = v_place;
                        ao_we = 1'b1;
                        ao_wa = v_idx;
                        ao_wd = a_ent;
                    end
                    else
                    begin
                        ap_we = 1'b1;
                        ap_wa = ao_q;
                        ap_wd = v_place;
                        ao_we = 1'b1;
                        ao_wa = v_idx;
                        ao_wd = ao_q;
                        op_we = 1'b1;
                        op_wa = o_ent;
                        op_wd = v_place;
                        oo_we = 1'b1;
                        oo_wa = v_idx;
                        oo_wd = o_ent;
                    end
                end
            end
            tlom_pkg::S_WRITE:
            begin
                oo_we = wclr_o_reg;
                oo_wa = here_reg;
                ao_we = wclr_a_reg;
                ao_wa = here_reg;
            end
            default:
            begin
                op_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlom_pkg::S_CLEAR;
            clr_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tlom_pkg::S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (state_reg == tlom_pkg::S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == tlom_pkg::S_IDLE && cmd.valid)
        begin
            cmd_reg <= tlom_pkg::cmd_e'(cmd.command);
            ent_reg <= cmd.entity_num;
            vtx_reg <= cmd.vertex_num;
        end
        here_reg <= here_next;
        busy_reg <= busy_next;
        wclr_o_reg <= wclr_o_next;
        wclr_a_reg <= wclr_a_next;
        st_reg <= st_next;
        oh_reg <= oh_next;
        ah_reg <= ah_next;
        loc_reg <= loc_next;
        locv_reg <= locv_next;
        if (state_reg == tlom_pkg::S_DONE && out_free)
        begin
            out_st_reg <= st_reg;
            out_oh_reg <= oh_reg;
            out_ah_reg <= ah_reg;
            out_loc_reg <= loc_reg;
            out_locv_reg <= locv_reg;
        end
    end

    assign cmd.ready = (state_reg == tlom_pkg::S_IDLE);

    assign res.valid = out_valid_reg;
    assign res.status = out_st_reg;
    assign res.object_here = out_oh_reg;
    assign res.agent_here = out_ah_reg;
    assign res.location = out_loc_reg;
    assign res.location_valid = out_locv_reg;

`ifndef SYNTHESIS
    a_no_write_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tlom_pkg::S_IDLE || state_reg == tlom_pkg::S_DONE)
        |-> !(op_we || oo_we || ap_we || ao_we))
        else $error("Memory written while no command is in progress.");

    a_write_step_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tlom_pkg::S_WRITE |-> (wclr_o_reg || wclr_a_reg))
        else $error("Vacating step entered with nothing to vacate.");

    a_carry_leaves_vertex: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tlom_pkg::S_CARRY && cr_st == tlom_pkg::ST_OK) |-> here_reg != v_idx)
        else $error("Combined move onto the mover's own vertex.");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == tlom_pkg::S_DONE)
        else $error("Result item raised outside the completion step.");
`endif

endmodule

[tb/tlom_map_checker.sv]
// Scoreboard of the two-layer occupancy map: keeps its own copy of both layers,
// predicts one result per accepted command and compares it with the result channel.
// Depends on tlom_pkg and the channel interfaces in tlom_if.
`timescale 1ns / 1ps

module tlom_map_checker
    import tlom_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    tlom_cmd_if    cmd,
    tlom_res_if    res,
    output int     fail_count,
    output int     outstanding
);

    localparam int VERTICES = VERTICES_DEF;
    localparam int OBJECTS = OBJECTS_DEF;
    localparam int AGENTS = AGENTS_DEF;
    localparam int LAYER_OBJ = 0;
    localparam int LAYER_AGENT = 1;

    typedef struct packed {
        status_e           status;
        logic [ID_W-1:0]   object_here;
        logic [ID_W-1:0]   agent_here;
        logic [ID_W-1:0]   location;
        logic              location_valid;
    } map_result_t;

    bit              placed   [2][64];
    logic [ID_W-1:0] spot     [2][64];
    logic [ID_W-1:0] occupant [2][64];
    map_result_t     pending_results[$];
    int              errors = 0;

    function automatic bit id_ok(int l, logic [ID_W-1:0] e);
        return e != 0 && int'(e) <= ((l == LAYER_OBJ) ? OBJECTS : AGENTS);
    endfunction

    function automatic bit vertex_ok(logic [ID_W-1:0] v);
        return int'(v) < VERTICES;
    endfunction

    function automatic void stand(int l, logic [ID_W-1:0] e, logic [ID_W-1:0] v);
        if (placed[l][e])
        begin
            occupant[l][spot[l][e]] = '0;
        end
        placed[l][e] = 1'b1;
        spot[l][e] = v;
        occupant[l][v] = e;
    endfunction

    function automatic void lift(int l, logic [ID_W-1:0] e);
        if (placed[l][e])
        begin
            occupant[l][spot[l][e]] = '0;
        end
        placed[l][e] = 1'b0;
        spot[l][e] = '0;
    endfunction

    function automatic map_result_t next_map_result(logic [CMD_W-1:0] c,
                                                    logic [ID_W-1:0] e,
                                                    logic [ID_W-1:0] v);
        map_result_t     r;
        int              m;
        int              k;
        logic [ID_W-1:0] here;
        logic [ID_W-1:0] other;
        r = '0;
        r.status = ST_OK;
        case (c)
            CMD_PLACE_OBJ, CMD_PLACE_AGENT:
            begin
                m = (c == CMD_PLACE_OBJ) ? LAYER_OBJ : LAYER_AGENT;
                if (!id_ok(m, e) || !vertex_ok(v))
                    r.status = ST_BAD_ID;
                else if (occupant[m][v] != 0)
                    r.status = ST_OCCUPIED;
                else
                    stand(m, e, v);
            end
            CMD_REMOVE_OBJ, CMD_REMOVE_AGENT:
            begin
                m = (c == CMD_REMOVE_OBJ) ? LAYER_OBJ : LAYER_AGENT;
                if (!id_ok(m, e))
                    r.status = ST_BAD_ID;
                else if (!placed[m][e])
                    r.status = ST_UNPLACED;
                else
                    lift(m, e);
            end
            CMD_CLEAN:
            begin
                if (!vertex_ok(v))
                    r.status = ST_BAD_ID;
                else
                begin
                    for (int l = 0; l < 2; l++)
                    begin
                        if (occupant[l][v] != 0)
                            lift(l, occupant[l][v]);
                    end
                end
            end
            CMD_MOVE_AGENT:
            begin
                if (!id_ok(LAYER_AGENT, e) || !vertex_ok(v))
                    r.status = ST_BAD_ID;
                else if (!placed[LAYER_AGENT][e])
                    r.status = ST_UNPLACED;
                else if (occupant[LAYER_AGENT][v] != 0)
                    r.status = ST_OCCUPIED;
                else
                    stand(LAYER_AGENT, e, v);
            end
            CMD_AGENT_CARRY, CMD_OBJ_CARRY:
            begin
                m = (c == CMD_AGENT_CARRY) ? LAYER_AGENT : LAYER_OBJ;
                k = 1 - m;
                if (!id_ok(m, e) || !vertex_ok(v))
                    r.status = ST_BAD_ID;
                else if (!placed[m][e])
                    r.status = ST_UNPLACED;
                else
                begin
                    here = spot[m][e];
                    other = occupant[k][here];
                    if (other == 0)
                        r.status = ST_NOTHING;
                    else if (occupant[m][v] != 0 || occupant[k][v] != 0)
                        r.status = ST_OCCUPIED;
                    else
                    begin
                        stand(k, other, v);
                        stand(m, e, v);
                    end
                end
            end
            CMD_QUERY_VERTEX:
            begin
                if (!vertex_ok(v))
                    r.status = ST_BAD_ID;
                else
                begin
                    r.object_here = occupant[LAYER_OBJ][v];
                    r.agent_here = occupant[LAYER_AGENT][v];
                end
            end
            CMD_OBJ_LOC, CMD_AGENT_LOC:
            begin
                m = (c == CMD_OBJ_LOC) ? LAYER_OBJ : LAYER_AGENT;
                if (!id_ok(m, e))
                    r.status = ST_BAD_ID;
                else if (placed[m][e])
                begin
                    r.location = spot[m][e];
                    r.location_valid = 1'b1;
                end
            end
            default:
            begin
                r.status = ST_BAD_ID;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        map_result_t want;
        map_result_t got;
        if (!rst_n)
        begin
            for (int l = 0; l < 2; l++)
            begin
                for (int i = 0; i < 64; i++)
                begin
                    placed[l][i] = 1'b0;
                    spot[l][i] = '0;
                    occupant[l][i] = '0;
                end
            end
            pending_results.delete();
            outstanding <= 0;
            fail_count <= errors;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                got = {res.status, res.object_here, res.agent_here, res.location,
                       res.location_valid};
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no command pending: status %0d obj %0d agent %0d loc %0d valid %0b",
                             $time, got.status, got.object_here, got.agent_here,
                             got.location, got.location_valid);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t: mismatch: expected status %0d obj %0d agent %0d loc %0d valid %0b",
                                 $time, want.status, want.object_here, want.agent_here,
                                 want.location, want.location_valid);
                        $display("%0t:           actual status %0d obj %0d agent %0d loc %0d valid %0b",
                                 $time, got.status, got.object_here, got.agent_here,
                                 got.location, got.location_valid);
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                pending_results.push_back(next_map_result(cmd.command, cmd.entity_num,
                                                          cmd.vertex_num));
            end
            outstanding <= pending_results.size();
            fail_count <= errors;
        end
    end

endmodule

[tb/tb_two_layer_occupancy_map.sv]
// Testbench top of the two-layer occupancy map: clock, reset, command stimulus and
// result back-pressure in several idling phases, and the final verdict.
// Depends on tlom_pkg, tlom_if, the block itself and tlom_map_checker.
`timescale 1ns / 1ps

module tb_two_layer_occupancy_map;
    import tlom_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 4'd11;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LAST = 4'd15;
    localparam int PHASE_ITEMS = 270;
    localparam int HOLD_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   outstanding;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_requests = 0;

    tlom_cmd_if cmd_ch ();
    tlom_res_if res_ch ();

    two_layer_occupancy_map u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    tlom_map_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .res         (res_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int hold_left;
        int hold_served;
        hold_left = 0;
        hold_served = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_served)
            begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic issue(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] e,
                         input logic [ID_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= c;
        cmd_ch.entity_num <= e;
        cmd_ch.vertex_num <= v;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    function automatic logic [ID_W-1:0] pick_entity();
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return '0;
        else if (r < 12)
            return ID_W'($urandom_range(63));
        else
            return ID_W'($urandom_range(1, 10));
    endfunction

    function automatic logic [ID_W-1:0] pick_vertex();
        if ($urandom_range(99) < 15)
            return ID_W'($urandom_range(63));
        else
            return ID_W'($urandom_range(15));
    endfunction

    task automatic random_traffic(input int count);
        int sent;
        logic [CMD_W-1:0] c;
        logic [ID_W-1:0] o;
        logic [ID_W-1:0] a;
        logic [ID_W-1:0] v;
        logic [ID_W-1:0] w;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 30)
            begin
                // An object and an agent meet on one vertex, then one carries the other.
                o = ID_W'($urandom_range(1, 10));
                a = ID_W'($urandom_range(1, 10));
                v = ID_W'($urandom_range(15));
                w = pick_vertex();
                issue(CMD_PLACE_OBJ, o, v);
                issue(CMD_PLACE_AGENT, a, v);
                if ($urandom_range(1) == 1)
                    issue(CMD_AGENT_CARRY, a, w);
                else
                    issue(CMD_OBJ_CARRY, o, w);
                issue(CMD_QUERY_VERTEX, pick_entity(), w);
                sent += 4;
            end
            else
            begin
                if ($urandom_range(99) < 4)
                    c = CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
                else
                    c = CMD_W'($urandom_range(CMD_PLACE_OBJ, CMD_AGENT_LOC));
                issue(c, pick_entity(), pick_vertex());
                sent++;
            end
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        random_traffic(count);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.command <= CMD_QUERY_VERTEX;
        cmd_ch.entity_num <= '0;
        cmd_ch.vertex_num <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        issue(CMD_QUERY_VERTEX, 6'd0, 6'd0);
        issue(CMD_OBJ_LOC, 6'd1, 6'd0);
        issue(CMD_PLACE_OBJ, 6'd0, 6'd5);
        issue(CMD_PLACE_OBJ, 6'd63, 6'd63);
        issue(CMD_PLACE_AGENT, 6'd63, 6'd63);
        issue(CMD_PLACE_OBJ, 6'd1, 6'd63);
        issue(CMD_PLACE_OBJ, 6'd63, 6'd63);
        issue(CMD_REMOVE_OBJ, 6'd2, 6'd0);
        issue(CMD_MOVE_AGENT, 6'd5, 6'd3);
        issue(CMD_AGENT_CARRY, 6'd4, 6'd1);
        issue(CMD_PLACE_AGENT, 6'd1, 6'd0);
        issue(CMD_AGENT_CARRY, 6'd1, 6'd10);
        issue(CMD_PLACE_OBJ, 6'd2, 6'd0);
        issue(CMD_AGENT_CARRY, 6'd1, 6'd63);
        issue(CMD_AGENT_CARRY, 6'd1, 6'd10);
        issue(CMD_OBJ_CARRY, 6'd2, 6'd20);
        issue(CMD_PLACE_OBJ, 6'd2, 6'd30);
        issue(CMD_QUERY_VERTEX, 6'd63, 6'd20);
        issue(CMD_MOVE_AGENT, 6'd1, 6'd30);
        issue(CMD_CLEAN, 6'd0, 6'd30);
        issue(CMD_CLEAN, 6'd0, 6'd30);
        issue(CMD_CLEAN, 6'd0, 6'd63);
        issue(CMD_AGENT_LOC, 6'd63, 6'd0);
        issue(CMD_UNUSED_FIRST, 6'd1, 6'd1);
        issue(CMD_UNUSED_LAST, 6'd63, 6'd63);

        run_phase(0, 0, PHASE_ITEMS);
        run_phase(82, 0, PHASE_ITEMS);
        run_phase(0, 82, PHASE_ITEMS);
        run_phase(6, 6, PHASE_ITEMS);
        hold_requests <= hold_requests + 1;
        run_phase(0, 0, PHASE_ITEMS);
        cmd_ch.valid <= 1'b0;

        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
